[sv/nrsh_pkg.sv]
// shared types and constants for the nearest ray segment hit block
package nrsh_pkg;

    localparam int DIST_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 4;
    localparam int FIELD_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_LENGTH = 2'd2;

    localparam logic [CFG_W-1:0]  RAY_LENGTH_RESET = 16'd160;
    localparam logic [DIST_W-1:0] DIST_ALL_ONES    = '1;

    // index of the last multiplier slot; slots 0 to 5 carry the cross product terms
    localparam logic [CNT_W-1:0] MUL_LAST = 4'd6;
    // one quotient bit per divider step
    localparam logic [CNT_W-1:0] DIV_LAST = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_NORM,
        ST_SCALE,
        ST_DIV,
        ST_UPDATE
    } nrsh_state_t;

endpackage

[sv/nearest_ray_segment_hit_core.sv]
// nearest ray segment hit: sequenced cross products, range check and divider
//
// usage: write light_x, light_y and ray_length on the cfg port (index 0, 1, 2)
// while the core is idle. each transfer on the s_ channel carries the ray end
// point and one wall segment; s_tlast marks the last segment of a ray. the
// core keeps the nearest hit over the segments of a ray and, after the segment
// marked last, places one transfer on the m_ channel: m_tuser is the hit flag,
// m_tdata the distance (all ones when nothing was hit). the minimum is then
// cleared for the next ray.
// datapath: one shared signed multiplier forms the six products of the three
// cross products, then the ST_NORM state fixes the sign of the denominator and
// ST_SCALE scales the hit fraction by ray_length. a segment that passes the
// range check then runs a 16 step restoring divider, one quotient bit per
// cycle; a segment that misses goes straight to the update. the result of a
// last segment shows on m_tvalid in the cycle after its update.
// s_tready is high only while the core is idle.
// stall: the result sits in an output register; a new segment is accepted
// while it waits, and a following last segment holds in its update cycle
// until the register is free.
// reset: config returns to light (0, 0) and ray_length 160, the minimum is
// cleared and the output register is emptied.
module nearest_ray_segment_hit_core
    import nrsh_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // segment input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // ray_end_x, ray_end_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
    input  logic [6*FIELD_W-1:0] s_tdata,
    input  logic                 s_tlast,   // last_segment
    // result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DIST_W-1:0]    m_tdata,   // distance
    output logic                 m_tuser    // hit
);

    // effective coordinate width: low bits sign extended, or the whole
    // 16 bit field taken as non-negative when the width is beyond it
    localparam int EW = (COORD_WIDTH <= FIELD_W) ? COORD_WIDTH : FIELD_W + 1;
    localparam int DW = EW + 1;          // coordinate differences
    localparam int MW = 2 * DW;          // one cross product
    localparam int PW = 2 * DW + 1;      // alpha, beta, denominator
    localparam int NW = PW - 1 + DIST_W; // scaled numerator

    function automatic logic signed [EW-1:0] coord_ext(input logic [FIELD_W-1:0] v);
        logic [31:0] vz;
        vz = {16'b0, v};
        return signed'(vz[EW-1:0]);
    endfunction

    // config registers
    logic [CFG_W-1:0] light_x_reg;
    logic [CFG_W-1:0] light_y_reg;
    logic [CFG_W-1:0] ray_length_reg;

    // control
    nrsh_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             any_hit_reg, any_hit_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic             out_valid_reg, out_valid_next;

    // datapath
    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [DW-1:0] ax_next, ay_next, bx_next, by_next, cx_next, cy_next;
    logic                 last_reg, last_next;
    logic signed [MW-1:0] prod_reg, prod_next;
    logic signed [PW-1:0] alpha_reg, beta_reg, den_reg;
    logic signed [PW-1:0] alpha_next, beta_next, den_next;
    logic [PW-2:0]        rem_reg, rem_next;
    logic [DIST_W-1:0]    quo_reg, quo_next;
    logic                 hit_ok_reg, hit_ok_next;
    logic                 out_hit_reg, out_hit_next;
    logic [DIST_W-1:0]    out_dist_reg, out_dist_next;

    // shared multiplier operands
    logic signed [DW-1:0] mul_a, mul_b;

    // accumulator
    logic [2:0]           acc_k;
    logic signed [PW-1:0] acc_base, acc_sum;

    // scale and divider
    logic [NW-1:0]        num;
    logic [PW-1:0]        div_t, div_d, div_diff;
    logic                 div_ge;
    logic                 range_ok;
    logic                 take;
    logic                 out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_dist_reg;
    assign m_tuser  = out_hit_reg;

    assign out_free = !out_valid_reg || m_tready;

    // config writes, out of range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg    <= '0;
            light_y_reg    <= '0;
            ray_length_reg <= RAY_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LIGHT_X:    light_x_reg    <= cfg_data;
                REG_LIGHT_Y:    light_y_reg    <= cfg_data;
                REG_RAY_LENGTH: ray_length_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // multiplier operand select, one cross product term per slot
    always_comb
    begin
        case (cnt_reg[2:0])
            3'd0:    begin mul_a = by_reg; mul_b = cx_reg; end
            3'd1:    begin mul_a = bx_reg; mul_b = cy_reg; end
            3'd2:    begin mul_a = ax_reg; mul_b = cy_reg; end
            3'd3:    begin mul_a = ay_reg; mul_b = cx_reg; end
            3'd4:    begin mul_a = ay_reg; mul_b = bx_reg; end
            3'd5:    begin mul_a = ax_reg; mul_b = by_reg; end
            default: begin mul_a = ax_reg; mul_b = ax_reg; end
        endcase
    end

    // accumulate the product from the slot before: even slot loads, odd subtracts
    always_comb
    begin
        acc_k = cnt_reg[2:0] - 3'd1;
        case (acc_k[2:1])
            2'd0:    acc_base = alpha_reg;
            2'd1:    acc_base = beta_reg;
            default: acc_base = den_reg;
        endcase
        if (acc_k[0])
            acc_sum = acc_base - PW'(prod_reg);
        else
            acc_sum = PW'(prod_reg);
    end

    // range check on normalized terms, both ends inside
    assign range_ok = (den_reg != '0) && !alpha_reg[PW-1] && !beta_reg[PW-1]
                   && (alpha_reg <= den_reg) && (beta_reg <= den_reg);

    assign num = NW'(alpha_reg[PW-2:0]) * NW'(ray_length_reg);

    // restoring divider step
    assign div_t    = {rem_reg, quo_reg[DIST_W-1]};
    assign div_d    = unsigned'(den_reg);
    assign div_ge   = (div_t >= div_d);
    assign div_diff = div_t - div_d;

    assign take = hit_ok_reg && (!any_hit_reg || (quo_reg < best_reg));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        any_hit_next   = any_hit_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_hit_next   = out_hit_reg;
        out_dist_next  = out_dist_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        alpha_next     = alpha_reg;
        beta_next      = beta_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        hit_ok_next    = hit_ok_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ax_next   = DW'(coord_ext(s_tdata[15:0]))  - DW'(coord_ext(light_x_reg));
                    ay_next   = DW'(coord_ext(s_tdata[31:16])) - DW'(coord_ext(light_y_reg));
                    bx_next   = DW'(coord_ext(s_tdata[47:32])) - DW'(coord_ext(s_tdata[79:64]));
                    by_next   = DW'(coord_ext(s_tdata[63:48])) - DW'(coord_ext(s_tdata[95:80]));
                    cx_next   = DW'(coord_ext(light_x_reg)) - DW'(coord_ext(s_tdata[47:32]));
                    cy_next   = DW'(coord_ext(light_y_reg)) - DW'(coord_ext(s_tdata[63:48]));
                    last_next = s_tlast;
                    cnt_next  = '0;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                prod_next = MW'(mul_a) * MW'(mul_b);
                if (cnt_reg != '0)
                begin
                    case (acc_k[2:1])
                        2'd0:    alpha_next = acc_sum;
                        2'd1:    beta_next  = acc_sum;
                        default: den_next   = acc_sum;
                    endcase
                end
                if (cnt_reg == MUL_LAST)
                    state_next = ST_NORM;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            ST_NORM:
            begin
                // make the denominator positive, flipping the parameters with it
                if (den_reg[PW-1])
                begin
                    alpha_next = -alpha_reg;
                    beta_next  = -beta_reg;
                    den_next   = -den_reg;
                end
                state_next = ST_SCALE;
            end

            ST_SCALE:
            begin
                hit_ok_next = range_ok;
                rem_next    = num[NW-1:DIST_W];
                quo_next    = num[DIST_W-1:0];
                cnt_next    = '0;
                state_next  = range_ok ? ST_DIV : ST_UPDATE;
            end

            ST_DIV:
            begin
                rem_next = div_ge ? div_diff[PW-2:0] : div_t[PW-2:0];
                quo_next = {quo_reg[DIST_W-2:0], div_ge};
                if (cnt_reg == DIV_LAST)
                    state_next = ST_UPDATE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            ST_UPDATE:
            begin
                if (!last_reg)
                begin
                    if (take)
                    begin
                        best_next    = quo_reg;
                        any_hit_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = any_hit_reg || take;
                    out_dist_next  = take ? quo_reg : best_reg;
                    best_next      = DIST_ALL_ONES;
                    any_hit_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            any_hit_reg   <= 1'b0;
            best_reg      <= DIST_ALL_ONES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            any_hit_reg   <= any_hit_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        last_reg     <= last_next;
        prod_reg     <= prod_next;
        alpha_reg    <= alpha_next;
        beta_reg     <= beta_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        hit_ok_reg   <= hit_ok_next;
        out_hit_reg  <= out_hit_next;
        out_dist_reg <= out_dist_next;
    end

endmodule
